FILE: hdl/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared item codes and register map for the table-driven DFA matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

  // Item kind codes
  typedef enum logic [1:0] {
    KIND_FEED    = 2'd0,
    KIND_TRANS   = 2'd1,
    KIND_FLAG    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  // Configuration port: byte address width and register index
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam logic        REG_START = 1'b0;

endpackage : dfa_pkg

`default_nettype wire

FILE: hdl/dfa_transition_matcher.sv
// ----------------------------------------------------------------------------
// dfa_transition_matcher
// Table-driven DFA matcher: programs transitions and accepting flags, restarts
// at the configured start state and steps one character per beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in_     | in_valid / in_stall   | kind, symbol, from_state, target_state,
//          |                       | marked_state, accept_flag
//  out_    | out_valid / out_stall | current_state, accepting
//  cfg_    | APB write/read        | start_state at byte address 0
//
//  One beat per cycle in when not stalled, one result beat per input beat.
//  The transition RAM's registered read data feeds the next lookup address
//  directly, so back-to-back characters need no bubble.
//  After reset a clearing pass sweeps STATE_COUNT * 2**clog2(ALPHABET_SIZE)
//  entries (8192 at default), one per cycle, with in_stall held high.
//  Output stalls back up one stage at a time; input also stalls when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_transition_matcher #(
  parameter int unsigned STATE_COUNT   = 64,
  parameter int unsigned ALPHABET_SIZE = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] in_symbol,
  input  wire logic [$clog2(STATE_COUNT)-1:0] in_from_state,
  input  wire logic signed [$clog2(STATE_COUNT):0] in_target_state,
  input  wire logic [$clog2(STATE_COUNT)-1:0] in_marked_state,
  input  wire logic                           in_accept_flag,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [$clog2(STATE_COUNT):0] out_current_state,
  output logic                                out_accepting,
  // configuration port
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [dfa_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [dfa_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [dfa_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned SW        = $clog2(STATE_COUNT);
  localparam int unsigned YW        = $clog2(ALPHABET_SIZE);
  localparam int unsigned AW        = SW + YW;
  localparam int unsigned MEM_DEPTH = STATE_COUNT * (2 ** YW);
  localparam int unsigned EW        = SW + 1;   // {link valid, destination}

  // Storage
  logic [EW-1:0] tran_mem [MEM_DEPTH];
  logic          flag_mem [STATE_COUNT];

  // Control and pipeline registers
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;
  logic [SW-1:0] start_r;
  logic          ps_alive_r;
  logic [SW-1:0] ps_state_r;
  logic          s1_valid_r, s1_feed_r, s1_symok_r, s1_alive_r;
  logic [SW-1:0] s1_state_r;
  logic [EW-1:0] tran_rd_r;
  logic          out_valid_r, out_alive_r, flag_rd_r;
  logic [SW-1:0] out_state_r;

  logic          accept, out_free, s1_adv, cfg_wr;
  logic          sym_ok, from_ok, mark_ok, tgt_ok, start_ok;
  logic          res_alive, cur_alive;
  logic [SW-1:0] res_state, cur_state;
  logic          s1_alive_nxt;
  logic [SW-1:0] s1_state_nxt;
  logic          tr_we, tr_re, fl_we;
  logic [AW-1:0] tr_addr;
  logic [EW-1:0] tr_wdata;
  logic [SW-1:0] fl_addr;
  logic          fl_wdata;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = clr_busy_r || (s1_valid_r && !out_free);
  assign accept   = in_valid && !in_stall;

  // Range checks
  assign sym_ok   = {1'b0, in_symbol} < (YW + 1)'(ALPHABET_SIZE);
  assign from_ok  = {1'b0, in_from_state} < (SW + 1)'(STATE_COUNT);
  assign mark_ok  = {1'b0, in_marked_state} < (SW + 1)'(STATE_COUNT);
  assign tgt_ok   = !in_target_state[SW]
                    && ({1'b0, in_target_state[SW-1:0]} < (SW + 1)'(STATE_COUNT));
  assign start_ok = {1'b0, start_r} < (SW + 1)'(STATE_COUNT);

  // Resolve the state after the item in stage 1
  always_comb begin
    res_alive = s1_alive_r;
    res_state = s1_state_r;
    if (s1_feed_r) begin
      res_alive = s1_alive_r && s1_symok_r && tran_rd_r[SW];
      res_state = tran_rd_r[SW-1:0];
    end
    if (!res_alive) begin
      res_state = '0;
    end
  end

  // Forward the freshest state to the next lookup
  assign cur_alive = s1_valid_r ? res_alive : ps_alive_r;
  assign cur_state = s1_valid_r ? res_state : ps_state_r;

  // Stage 1 state view for the accepted item
  always_comb begin
    s1_alive_nxt = cur_alive;
    s1_state_nxt = cur_state;
    if (in_kind == dfa_pkg::KIND_RESTART) begin
      s1_alive_nxt = start_ok;
      s1_state_nxt = start_ok ? start_r : '0;
    end
  end

  // Transition RAM port: clearing pass, transition write or feed lookup
  always_comb begin
    tr_we    = 1'b0;
    tr_re    = 1'b0;
    tr_addr  = {cur_state, in_symbol};
    tr_wdata = '0;
    if (clr_busy_r) begin
      tr_we   = 1'b1;
      tr_addr = clr_idx_r;
    end else if (accept && in_kind == dfa_pkg::KIND_TRANS) begin
      tr_we    = from_ok && sym_ok;
      tr_addr  = {in_from_state, in_symbol};
      tr_wdata = tgt_ok ? {1'b1, in_target_state[SW-1:0]} : '0;
    end else if (accept && in_kind == dfa_pkg::KIND_FEED) begin
      tr_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tran_mem[tr_addr] <= tr_wdata;
    end
    if (tr_re) begin
      tran_rd_r <= tran_mem[tr_addr];
    end
  end

  // Accepting flag RAM: write on accept, read when stage 1 moves on
  always_comb begin
    fl_we    = 1'b0;
    fl_addr  = in_marked_state;
    fl_wdata = in_accept_flag;
    if (clr_busy_r) begin
      fl_we    = clr_idx_r < AW'(STATE_COUNT);
      fl_addr  = clr_idx_r[SW-1:0];
      fl_wdata = 1'b0;
    end else if (accept && in_kind == dfa_pkg::KIND_FLAG) begin
      fl_we = mark_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flag_mem[fl_addr] <= fl_wdata;
    end
    if (s1_adv) begin
      flag_rd_r <= flag_mem[res_state];
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(MEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Configuration register
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == dfa_pkg::REG_START)
                      ? dfa_pkg::CFG_DW'(start_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == dfa_pkg::REG_START) begin
      start_r <= cfg_pwdata[SW-1:0];
    end
  end

  // Stage 1 and committed present state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ps_alive_r <= 1'b1;
      ps_state_r <= '0;
    end else begin
      if (s1_adv) begin
        ps_alive_r <= res_alive;
        ps_state_r <= res_state;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_feed_r  <= in_kind == dfa_pkg::KIND_FEED;
      s1_symok_r <= sym_ok;
      s1_alive_r <= s1_alive_nxt;
      s1_state_r <= s1_state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_alive_r <= res_alive;
      out_state_r <= res_state;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_state = out_alive_r ? $signed({1'b0, out_state_r}) : '1;
  assign out_accepting     = out_alive_r && flag_rd_r;

endmodule : dfa_transition_matcher

`default_nettype wire

FILE: hdl/dfa_checker.sv
// ----------------------------------------------------------------------------
// dfa_checker
// Port-level checks on the DFA matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_checker #(
  parameter int unsigned STATE_COUNT = 64
) (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic signed [$clog2(STATE_COUNT):0]   out_current_state,
  input wire logic                                  out_accepting
);

  localparam int unsigned SW = $clog2(STATE_COUNT);

  // Reset starts the clearing pass, so no beat is taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // Dead state is never accepting
  a_dead_not_accepting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_state[SW] |-> !out_accepting)
    else $error("dead state reported accepting");

  // Reported state is dead (all ones) or a real state
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_current_state == '1)
                  || (!out_current_state[SW]
                      && ({1'b0, out_current_state[SW-1:0]} < (SW + 1)'(STATE_COUNT))))
    else $error("reported state out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_state)
                               && $stable(out_accepting))
    else $error("stalled result changed");

endmodule : dfa_checker

bind dfa_transition_matcher dfa_checker #(
  .STATE_COUNT(STATE_COUNT)
) u_dfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_current_state(out_current_state),
  .out_accepting    (out_accepting)
);

`default_nettype wire

FILE: dv/dfa_transition_checker.sv
// ----------------------------------------------------------------------------
// dfa_transition_checker
// Watches the item, result and register ports of the DFA matcher. It keeps its
// own copy of the transition store, the accepting flags and the walk state,
// works out the result of every accepted item and checks it against the
// result beats in order. It also checks register reads against the last write.
// ----------------------------------------------------------------------------
module dfa_transition_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [6:0]                    in_symbol,
  input  wire logic [5:0]                    in_from_state,
  input  wire logic signed [6:0]             in_target_state,
  input  wire logic [5:0]                    in_marked_state,
  input  wire logic                          in_accept_flag,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic signed [6:0]             out_current_state,
  input  wire logic                          out_accepting,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [dfa_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [dfa_pkg::CFG_DW-1:0]    cfg_pwdata,
  input  wire logic [dfa_pkg::CFG_DW-1:0]    cfg_prdata,
  input  wire logic                          cfg_pready,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STATES  = 64;
  localparam int unsigned SYMBOLS = 128;
  localparam logic [dfa_pkg::CFG_AW-1:0] START_ADDR =
    dfa_pkg::CFG_AW'(4 * dfa_pkg::REG_START);

  typedef struct packed {
    logic signed [6:0] state;
    logic              accepting;
  } dfa_result_t;

  // Shadow of the matcher's tables and walk
  bit          link_live  [STATES*SYMBOLS];
  logic [5:0]  link_dest  [STATES*SYMBOLS];
  bit          accept_bit [STATES];
  bit          alive;
  logic [5:0]  here;
  logic [5:0]  start_copy;

  dfa_result_t result_q [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR result beat %0d: %s", $realtime, beats_checked, msg);
    mismatches++;
  endtask

  // Applies one item to the shadow and returns the state it leaves.
  // All field ranges fit the default table sizes, so no range checks apply.
  function automatic dfa_result_t walk_item(dfa_pkg::kind_t kind, logic [6:0] sym,
                                            logic [5:0] from, logic signed [6:0] tgt,
                                            logic [5:0] mark, logic flag);
    int unsigned slot;
    dfa_result_t r;
    case (kind)
      dfa_pkg::KIND_FEED: begin
        // dead is sticky; a missing link kills the walk
        if (alive) begin
          slot = int'({here, sym});
          if (link_live[slot]) begin
            here = link_dest[slot];
          end else begin
            alive = 1'b0;
            here  = '0;
          end
        end
      end
      dfa_pkg::KIND_TRANS: begin
        // any negative target clears the link
        slot = int'({from, sym});
        link_live[slot] = !tgt[6];
        link_dest[slot] = tgt[6] ? 6'd0 : tgt[5:0];
      end
      dfa_pkg::KIND_FLAG: begin
        accept_bit[mark] = flag;
      end
      default: begin
        alive = 1'b1;
        here  = start_copy;
      end
    endcase
    r.state     = alive ? $signed({1'b0, here}) : -7'sd1;
    r.accepting = alive && accept_bit[here];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    dfa_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < STATES*SYMBOLS; i++) begin
        link_live[i] = 1'b0;
        link_dest[i] = '0;
      end
      for (int i = 0; i < STATES; i++) accept_bit[i] = 1'b0;
      start_copy = '0;
      alive      = 1'b1;
      here       = '0;
      result_q.delete();
      mismatches    = 0;
      pending       <= 0;
      beats_checked <= 0;
    end else begin
      // register port
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == START_ADDR) begin
        if (cfg_pwrite) begin
          start_copy = cfg_pwdata[5:0];
        end else if (cfg_prdata !== dfa_pkg::CFG_DW'(start_copy)) begin
          report_mismatch($sformatf("start_state read %0d, last written %0d",
                                    cfg_prdata, start_copy));
        end
      end

      // item beat
      if (in_valid && !in_stall)
        result_q.push_back(walk_item(dfa_pkg::kind_t'(in_kind), in_symbol,
                                     in_from_state, in_target_state,
                                     in_marked_state, in_accept_flag));

      // result beat
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, state %0d accepting %0b",
                                    out_current_state, out_accepting));
        end else begin
          want = result_q.pop_front();
          if (out_current_state !== want.state)
            report_mismatch($sformatf("current_state got %0d want %0d",
                                      out_current_state, want.state));
          if (out_accepting !== want.accepting)
            report_mismatch($sformatf("accepting got %0b want %0b",
                                      out_accepting, want.accepting));
        end
        beats_checked <= beats_checked + 1;
      end
      pending <= result_q.size();
    end
  end

endmodule : dfa_transition_checker

FILE: dv/tb_dfa_transition_matcher.sv
// ----------------------------------------------------------------------------
// tb_dfa_transition_matcher
// Drives the DFA matcher with a directed pass over table extremes and the dead
// state, then with random small automata: each phase sets a start state,
// programs a few states over a few symbols (with holes and cleared links),
// marks accepting states and walks strings through them, mixed with noise.
// Both sides idle at random; the checker module judges every result beat.
// ----------------------------------------------------------------------------
module tb_dfa_transition_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1150;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_CYCLES = 64;
  localparam int IDLE_LIMIT  = 40000;
  localparam logic [dfa_pkg::CFG_AW-1:0] START_ADDR =
    dfa_pkg::CFG_AW'(4 * dfa_pkg::REG_START);

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 in_kind;
  logic [6:0]                 in_symbol;
  logic [5:0]                 in_from_state;
  logic signed [6:0]          in_target_state;
  logic [5:0]                 in_marked_state;
  logic                       in_accept_flag;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [6:0]          out_current_state;
  logic                       out_accepting;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [dfa_pkg::CFG_AW-1:0] cfg_paddr;
  logic [dfa_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [dfa_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  int mismatches;
  int pending;
  int beats_checked;

  int items_sent;
  int start_writes;
  bit tx_busy;
  bit rx_busy;
  int hold_ticket;
  int hold_served;

  dfa_transition_matcher dut (.*);

  dfa_transition_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall before each beat, plus one long hold on request
  initial begin : result_sink
    int n;
    out_stall   = 1'b0;
    hold_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = rx_busy ? $urandom_range(0, 6) : 0;
      if (hold_ticket != hold_served) begin
        n = HOLD_CYCLES;
        hold_served++;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("[%0t] watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One item beat, after a random gap; payload holds while stalled
  task automatic send(dfa_pkg::kind_t kind, logic [6:0] sym, logic [5:0] from,
                      logic signed [6:0] tgt, logic [5:0] mark, logic flag);
    int gap;
    gap = tx_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_symbol       <= sym;
    in_from_state   <= from;
    in_target_state <= tgt;
    in_marked_state <= mark;
    in_accept_flag  <= flag;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Shorthands with random filler in the unused fields
  task automatic feed(logic [6:0] sym);
    send(dfa_pkg::KIND_FEED, sym, 6'($urandom), 7'($urandom), 6'($urandom),
         1'($urandom));
  endtask

  task automatic link(logic [5:0] from, logic [6:0] sym, logic signed [6:0] tgt);
    send(dfa_pkg::KIND_TRANS, sym, from, tgt, 6'($urandom), 1'($urandom));
  endtask

  task automatic mark(logic [5:0] st, logic flag);
    send(dfa_pkg::KIND_FLAG, 7'($urandom), 6'($urandom), 7'($urandom), st, flag);
  endtask

  task automatic restart();
    send(dfa_pkg::KIND_RESTART, 7'($urandom), 6'($urandom), 7'($urandom),
         6'($urandom), 1'($urandom));
  endtask

  // Sender stops until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB transfer to the start_state register: setup, then access
  task automatic cfg_access(bit write, logic [dfa_pkg::CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= START_ADDR;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_pass();
    restart();                   // start state 0 after reset
    mark(6'd0, 1'b1);
    mark(6'd63, 1'b1);
    link(6'd0, 7'd0, 7'sd63);
    link(6'd63, 7'd127, 7'sd0);
    link(6'd0, 7'd127, 7'sd0);   // self loop
    feed(7'd127);
    feed(7'd0);                  // to the top state
    mark(6'd63, 1'b0);           // flag write seen at once
    feed(7'd127);
    link(6'd0, 7'd5, -7'sd64);   // most negative target clears
    feed(7'd5);                  // missing link: dead
    feed(7'd0);                  // dead stays dead
    mark(6'd0, 1'b1);
    link(6'd63, 7'd0, 7'sd1);
    restart();
    link(6'd0, 7'd0, -7'sd2);    // overwrite live link with no link
    feed(7'd0);
    restart();
    link(6'd0, 7'd0, -7'sd1);
    feed(7'd127);
    feed(7'd127);
  endtask

  // One random automaton: a few states over a few symbols, then walks
  task automatic random_phase(logic [5:0] start, bit pause_midway);
    logic [5:0] states [8];
    logic [6:0] syms [5];
    int state_total;
    int n_syms;
    int first;
    int len;
    int roll;
    bit paused;
    logic signed [6:0] tgt;
    first       = items_sent;
    paused      = 1'b0;
    state_total = $urandom_range(2, 8);
    n_syms      = $urandom_range(2, 5);
    states[0] = start;
    for (int i = 1; i < state_total; i++) states[i] = 6'($urandom);
    for (int i = 0; i < n_syms; i++) syms[i] = 7'($urandom);

    // program the table, with some holes
    for (int s = 0; s < state_total; s++) begin
      for (int c = 0; c < n_syms; c++) begin
        roll = $urandom_range(0, 15);
        if (roll == 0) tgt = -7'sd1;
        else if (roll == 1) tgt = 7'($urandom_range(64, 126));
        else tgt = $signed({1'b0, states[$urandom_range(0, state_total - 1)]});
        link(states[s], syms[c], tgt);
      end
    end
    for (int s = 0; s < state_total; s++) mark(states[s], 1'($urandom));

    // walk strings, with noise in between
    while (items_sent - first < PHASE_ITEMS) begin
      if (pause_midway && !paused && items_sent - first >= PHASE_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        send(dfa_pkg::kind_t'($urandom_range(0, 3)), 7'($urandom), 6'($urandom),
             7'($urandom), 6'($urandom), 1'($urandom));
      end else begin
        restart();
        len = $urandom_range(3, 16);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) feed(7'($urandom));
          else feed(syms[$urandom_range(0, n_syms - 1)]);
        end
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int phase;
    logic [5:0] start;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = dfa_pkg::KIND_FEED;
    in_symbol       = '0;
    in_from_state   = '0;
    in_target_state = '0;
    in_marked_state = '0;
    in_accept_flag  = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    items_sent      = 0;
    start_writes    = 0;
    tx_busy         = 1'b1;
    rx_busy         = 1'b1;
    hold_ticket     = 0;
    phase           = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    directed_pass();
    drain();

    while (items_sent < ITEM_TARGET) begin
      // start state: both extremes first, then random
      if (phase == 0) start = 6'd63;
      else if (phase == 1) start = 6'd0;
      else start = 6'($urandom);
      cfg_access(1'b1, {26'($urandom), start});
      cfg_access(1'b0, '0);
      start_writes++;

      // handshake pressure per phase
      if (phase == 2) begin
        tx_busy = 1'b0;
        rx_busy = 1'b0;
      end else if (phase == 3) begin
        tx_busy = 1'b0;
        rx_busy = 1'b1;
        hold_ticket++;
      end else begin
        tx_busy = ($urandom_range(0, 3) != 0);
        rx_busy = ($urandom_range(0, 3) != 0);
      end

      random_phase(start, phase == 4);
      drain();
      phase++;
    end
    repeat (8) @(posedge clk);

    $display("run: %0d item beats, %0d result beats checked, %0d start-state settings",
             items_sent, beats_checked, start_writes);
    $display("run: included a %0d-cycle result hold and drains between phases",
             HOLD_CYCLES);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : tb_dfa_transition_matcher
